// ===== design/pit_pkg.sv =====
package pit_pkg;

    localparam int CHANNELS    = 4;
    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int LINES       = 4;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register select codes
    localparam logic [2:0] SEL_LOAD  = 3'd0;
    localparam logic [2:0] SEL_COUNT = 3'd1;
    localparam logic [2:0] SEL_CTRL  = 3'd2;
    localparam logic [2:0] SEL_FLAG  = 3'd3;
    localparam logic [2:0] SEL_MCR   = 3'd4;

    // Bit positions
    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_IE_BIT  = 1;
    localparam int FLAG_BIT     = 0;
    localparam int MCR_DIS_BIT  = 1;

    typedef struct packed {
        logic                  tick;
        logic                  wr_load;
        logic                  wr_ctrl;
        logic                  wr_flag;
        logic [DATA_WIDTH-1:0] data;
    } chan_cmd_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] load;
        logic [COUNT_WIDTH-1:0] count;
        logic                   en;
        logic                   ie;
        logic                   flag;
        logic                   irq_next;
    } chan_stat_t;

endpackage

// ===== design/periodic_interrupt_timer.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | cmd, channel, reg_sel, write_data
// out     | output    | out_valid/out_ready | read_data, irq_lines, irq_any
//
// One transaction per clock while out_ready is high: an input register feeds one
// pass of channel update and read mux into the result register.
// Throughput is set by the result register; it frees when out_ready is high.
// Reset clears all channel state to zero and sets the module-disable bit.
// A stalled output holds the result; one more transaction waits in the
// input register, after which in_ready drops.
module periodic_interrupt_timer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     cmd,
    input  logic [1:0]                     channel,
    input  logic [2:0]                     reg_sel,
    input  logic [pit_pkg::DATA_WIDTH-1:0] write_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pit_pkg::DATA_WIDTH-1:0] read_data,
    output logic [pit_pkg::LINES-1:0]      irq_lines,
    output logic                           irq_any
);
    import pit_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic [1:0]            cmd_reg;
    logic [1:0]            channel_reg;
    logic [2:0]            sel_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    // Result register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] read_data_reg, read_data_next;
    logic [LINES-1:0]      irq_lines_reg, irq_lines_next;
    logic                  irq_any_reg, irq_any_next;

    logic                  mod_dis_reg, mod_dis_next;
    logic                  go;
    logic                  is_tick, is_write, is_read;
    logic                  ch_valid;

    chan_cmd_t             ch_cmd [CHANNELS];
    chan_stat_t            ch_stat [CHANNELS];
    logic [CHANNELS-1:0]   irq_all;

    // Process the held transaction when the result register is free or draining
    assign go       = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg     <= cmd;
            channel_reg <= channel;
            sel_reg     <= reg_sel;
            data_reg    <= write_data;
        end
    end

    // Command decode
    always_comb
    begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_read  = 1'b0;
        unique case (cmd_reg)
            CMD_TICK:  is_tick  = go;
            CMD_WRITE: is_write = go;
            CMD_READ:  is_read  = go;
            default:   ;
        endcase
    end

    assign ch_valid = 32'(channel_reg) < CHANNELS;

    // Module control is shared by all channels, channel field ignored
    always_comb
    begin
        mod_dis_next = mod_dis_reg;
        if (is_write && sel_reg == SEL_MCR)
        begin
            mod_dis_next = data_reg[MCR_DIS_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_dis_reg <= 1'b1;
        end
        else
        begin
            mod_dis_reg <= mod_dis_next;
        end
    end

    // Per-channel strobes and channel instances
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic hit;

        assign hit = is_write && (32'(channel_reg) == c);

        always_comb
        begin
            ch_cmd[c].tick    = is_tick && !mod_dis_reg;
            ch_cmd[c].wr_load = 1'b0;
            ch_cmd[c].wr_ctrl = 1'b0;
            ch_cmd[c].wr_flag = 1'b0;
            ch_cmd[c].data    = data_reg;
            unique case (sel_reg)
                SEL_LOAD: ch_cmd[c].wr_load = hit;
                SEL_CTRL: ch_cmd[c].wr_ctrl = hit;
                SEL_FLAG: ch_cmd[c].wr_flag = hit;
                default:  ;
            endcase
        end

        pit_channel u_chan
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd_in (ch_cmd[c]),
            .stat   (ch_stat[c])
        );

        assign irq_all[c] = ch_stat[c].irq_next;
    end

    // Read mux; state read is pre-update, which equals post-update for reads
    always_comb
    begin
        read_data_next = '0;
        if (is_read)
        begin
            if (sel_reg == SEL_MCR)
            begin
                read_data_next[MCR_DIS_BIT] = mod_dis_reg;
            end
            else if (ch_valid)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (32'(channel_reg) == i)
                    begin
                        unique case (sel_reg)
                            SEL_LOAD:  read_data_next = DATA_WIDTH'(ch_stat[i].load);
                            SEL_COUNT: read_data_next = DATA_WIDTH'(ch_stat[i].count);
                            SEL_CTRL:
                            begin
                                read_data_next[CTRL_EN_BIT] = ch_stat[i].en;
                                read_data_next[CTRL_IE_BIT] = ch_stat[i].ie;
                            end
                            SEL_FLAG:  read_data_next[FLAG_BIT] = ch_stat[i].flag;
                            default:   read_data_next = '0;
                        endcase
                    end
                end
            end
        end
    end

    // Lines show the first four channels only; the summary covers all
    always_comb
    begin
        irq_lines_next = '0;
        for (int i = 0; i < LINES; i++)
        begin
            if (i < CHANNELS)
            begin
                irq_lines_next[i] = irq_all[i];
            end
        end
        irq_any_next = |irq_all;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            read_data_reg <= read_data_next;
            irq_lines_reg <= irq_lines_next;
            irq_any_reg   <= irq_any_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_lines = irq_lines_reg;
    assign irq_any   = irq_any_reg;

endmodule

// ===== design/pit_channel.sv =====
module pit_channel
(
    input  logic               clk,
    input  logic               rst_n,
    input  pit_pkg::chan_cmd_t cmd_in,
    output pit_pkg::chan_stat_t stat
);
    import pit_pkg::*;

    logic [COUNT_WIDTH-1:0] load_reg, load_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   en_reg, en_next;
    logic                   ie_reg, ie_next;
    logic                   flag_reg, flag_next;

    always_comb
    begin
        load_next  = load_reg;
        count_next = count_reg;
        en_next    = en_reg;
        ie_next    = ie_reg;
        flag_next  = flag_reg;
        if (cmd_in.tick && en_reg)
        begin
            if (count_reg == '0)
            begin
                count_next = load_reg;
                flag_next  = 1'b1;
            end
            else
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        if (cmd_in.wr_load)
        begin
            load_next = cmd_in.data[COUNT_WIDTH-1:0];
        end
        if (cmd_in.wr_ctrl)
        begin
            // rising enable reloads the counter
            if (cmd_in.data[CTRL_EN_BIT] && !en_reg)
            begin
                count_next = load_reg;
            end
            en_next = cmd_in.data[CTRL_EN_BIT];
            ie_next = cmd_in.data[CTRL_IE_BIT];
        end
        if (cmd_in.wr_flag && cmd_in.data[FLAG_BIT])
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= '0;
            count_reg <= '0;
            en_reg    <= 1'b0;
            ie_reg    <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            load_reg  <= load_next;
            count_reg <= count_next;
            en_reg    <= en_next;
            ie_reg    <= ie_next;
            flag_reg  <= flag_next;
        end
    end

    assign stat.load     = load_reg;
    assign stat.count    = count_reg;
    assign stat.en       = en_reg;
    assign stat.ie       = ie_reg;
    assign stat.flag     = flag_reg;
    assign stat.irq_next = flag_next & ie_next;

endmodule
